FILE: hw/rtl/tscr_pkg.sv
`timescale 1ns / 1ps

package tscr_pkg;

    // Field widths
    localparam int ROW_W      = 6;
    localparam int COL_W      = 8;
    localparam int RU_W       = 7;   // rows in use, 1..63
    localparam int CU_W       = 9;   // columns in use, 1..255
    localparam int CELL_W     = 9;   // reverse bit over character byte
    localparam int MEM_AW_MAX = 14;  // 64 x 256 cells at most

    // Defaults
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 128;
    localparam int RST_ROWS     = 25;
    localparam int RST_COLS     = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Command codes
    localparam logic [3:0] ACT_PUT    = 4'd0;
    localparam logic [3:0] ACT_UP     = 4'd1;
    localparam logic [3:0] ACT_DOWN   = 4'd2;
    localparam logic [3:0] ACT_LEFT   = 4'd3;
    localparam logic [3:0] ACT_RIGHT  = 4'd4;
    localparam logic [3:0] ACT_HOME   = 4'd5;
    localparam logic [3:0] ACT_MOVETO = 4'd6;
    localparam logic [3:0] ACT_CLEAR  = 4'd7;
    localparam logic [3:0] ACT_ENTER  = 4'd8;
    localparam logic [3:0] ACT_SCROLL = 4'd9;
    localparam logic [3:0] ACT_TAB    = 4'd10;
    localparam logic [3:0] ACT_DELETE = 4'd11;
    localparam logic [3:0] ACT_READ   = 4'd12;
    localparam logic [3:0] ACT_WRITE  = 4'd13;
    localparam logic [3:0] ACT_QUOTES = 4'd14;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_BLANK,
        ST_TAB,
        ST_QUOTE,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] char_code;
        logic       reverse_video;
        logic       force_req;
        logic [4:0] target_row;
        logic [6:0] target_col;
    } cmd_t;

    typedef struct packed {
        logic             accepted;
        logic [ROW_W-1:0] cursor_row;
        logic [COL_W-1:0] cursor_col;
        logic [7:0]       cell_char;
        logic             cell_reverse;
        logic             quote_open;
    } res_t;

    typedef struct packed {
        logic                  en;
        logic [MEM_AW_MAX-1:0] addr;
        logic [CELL_W-1:0]     data;
    } mem_wr_t;

    typedef struct packed {
        logic                  en;
        logic [MEM_AW_MAX-1:0] addr;
    } mem_rd_t;

    // Column modulo the tab step (10), via reciprocal 205/2048, exact below 1029
    function automatic logic [3:0] col_mod_tab(input logic [COL_W-1:0] x);
        logic [15:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = {8'd0, x} * 16'd205;
        q = p[15:11];
        r = x - ({3'd0, q} * 8'd10);
        return r[3:0];
    endfunction

    // Row count as used: 1..max_rows
    function automatic logic [RU_W-1:0] clamp_rows(input logic [ROW_W-1:0] v,
                                                   input int max_rows);
        logic [RU_W-1:0] res;
        if (v == '0)
            res = RU_W'(1);
        else if (int'(v) > max_rows)
            res = RU_W'(max_rows);
        else
            res = {1'b0, v};
        return res;
    endfunction

    // Column count as used: 1..max_cols
    function automatic logic [CU_W-1:0] clamp_cols(input logic [COL_W-1:0] v,
                                                   input int max_cols);
        logic [CU_W-1:0] res;
        if (v == '0)
            res = CU_W'(1);
        else if (int'(v) > max_cols)
            res = CU_W'(max_cols);
        else
            res = {1'b0, v};
        return res;
    endfunction

endpackage

FILE: hw/rtl/tscr_mem.sv
`timescale 1ns / 1ps

module tscr_mem
    import tscr_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS
)
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  mem_rd_t           rd,
    output logic [CELL_W-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CELL_W-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr[AW-1:0]] <= wr.data;
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
            rdata <= mem[rd.addr[AW-1:0]];
    end

endmodule

FILE: hw/rtl/tscr_ctrl.sv
`timescale 1ns / 1ps

module tscr_ctrl
    import tscr_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_clr,
    input  logic [RU_W-1:0]   rows_used,
    input  logic [CU_W-1:0]   cols_used,
    input  logic              start,
    input  cmd_t              cmd,
    input  logic              slot_free,
    output logic              idle,
    output logic              fin,
    output res_t              res,
    output mem_wr_t           mem_wr,
    output mem_rd_t           mem_rd,
    input  logic [CELL_W-1:0] rdata
);

    localparam logic [ROW_W-1:0] ROW_LIM     = ROW_W'((MAX_ROWS > 63) ? 63 : MAX_ROWS);
    localparam logic [COL_W-1:0] COL_LIM     = COL_W'((MAX_COLS > 255) ? 255 : MAX_COLS);
    localparam logic [ROW_W-1:0] ROW_MAX_IDX = ROW_W'(MAX_ROWS - 1);
    localparam logic [COL_W-1:0] COL_MAX_IDX = COL_W'(MAX_COLS - 1);

    state_t                state_reg, state_next;
    logic [ROW_W-1:0]      cur_row_reg, cur_row_next;
    logic [COL_W-1:0]      cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]      wr_reg, wr_next;
    logic [COL_W-1:0]      wc_reg, wc_next;
    logic                  rd_done_reg, rd_done_next;
    logic                  pend_reg, pend_next;
    logic                  par_reg, par_next;
    logic                  cfg_clr_reg, cfg_clr_next;
    logic [MEM_AW_MAX-1:0] pw_addr_reg, pw_addr_next;
    cmd_t                  cmd_reg;

    function automatic logic [MEM_AW_MAX-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                        input logic [COL_W-1:0] c);
        return MEM_AW_MAX'(int'(r) * MAX_COLS + int'(c));
    endfunction

    // Shared conditions
    logic             cur_on, tgt_on, del_on, row_in;
    logic             row_ok_dn, col_ok_rt;
    logic [ROW_W-1:0] row_dn_f;
    logic             enter_scroll, one_row;
    logic [CU_W-1:0]  qlim;
    logic             quote_go, q_last;
    logic             walk_row_end, walk_col_end, walk_last, copy_row_end;
    logic             tab_stop;
    state_t           scroll_entry;

    assign row_in    = {1'b0, cur_row_reg} < rows_used;
    assign cur_on    = row_in && ({1'b0, cur_col_reg} < cols_used);
    assign tgt_on    = ({2'b0, cmd_reg.target_row} < rows_used)
                       && ({2'b0, cmd_reg.target_col} < cols_used);
    assign del_on    = row_in && ({1'b0, cur_col_reg - 8'd1} < cols_used);
    assign row_ok_dn = ({1'b0, cur_row_reg} + 7'd1) < rows_used;
    assign col_ok_rt = ({1'b0, cur_col_reg} + 9'd1) < cols_used;

    assign row_dn_f     = (cur_row_reg < ROW_LIM) ? cur_row_reg + 6'd1 : cur_row_reg;
    assign enter_scroll = {1'b0, row_dn_f} >= rows_used;
    assign one_row      = rows_used == 7'd1;
    assign scroll_entry = one_row ? ST_BLANK : ST_SCROLL;

    assign qlim     = ({1'b0, cur_col_reg} < cols_used) ? {1'b0, cur_col_reg} : cols_used;
    assign quote_go = row_in && (qlim != '0);
    assign q_last   = ({1'b0, wc_reg} + 9'd1) == qlim;

    // Sweep bounds: whole store after reset, visible screen otherwise
    assign walk_row_end = (state_reg == ST_INIT) ? (wr_reg == ROW_MAX_IDX)
                                                 : (({1'b0, wr_reg} + 7'd1) == rows_used);
    assign walk_col_end = (state_reg == ST_INIT) ? (wc_reg == COL_MAX_IDX)
                                                 : (({1'b0, wc_reg} + 9'd1) == cols_used);
    assign walk_last    = walk_row_end && walk_col_end;
    assign copy_row_end = ({1'b0, wr_reg} + 7'd2) == rows_used;

    // Tab stops off screen, at the last cell, or on a column whose index is a multiple of 10
    assign tab_stop = !cur_on
                      || (col_ok_rt ? (col_mod_tab(cur_col_reg) == 4'd0) : !row_ok_dn);

    assign idle = state_reg == ST_IDLE;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (walk_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (cfg_clr)
                    state_next = ST_CLEAR;
                else if (start)
                    state_next = ST_EXEC;
            ST_EXEC:
                if (slot_free)
                begin
                    case (cmd_reg.action)
                        ACT_CLEAR:  state_next = ST_CLEAR;
                        ACT_ENTER:  state_next = enter_scroll ? scroll_entry : ST_IDLE;
                        ACT_SCROLL: state_next = scroll_entry;
                        ACT_TAB:    state_next = ST_TAB;
                        ACT_READ:   state_next = tgt_on ? ST_READ : ST_IDLE;
                        ACT_QUOTES: state_next = quote_go ? ST_QUOTE : ST_IDLE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            ST_READ:
                if (slot_free)
                    state_next = ST_IDLE;
            ST_CLEAR:
                if (walk_last)
                    state_next = cfg_clr_reg ? ST_IDLE : ST_FIN;
            ST_SCROLL:
                if (rd_done_reg)
                    state_next = ST_BLANK;
            ST_BLANK:
                if (walk_col_end)
                    state_next = ST_FIN;
            ST_TAB:
                if (tab_stop)
                    state_next = ST_FIN;
            ST_QUOTE:
                if (rd_done_reg)
                    state_next = ST_FIN;
            ST_FIN:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory requests and result
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        wr_next      = wr_reg;
        wc_next      = wc_reg;
        rd_done_next = rd_done_reg;
        pend_next    = pend_reg;
        par_next     = par_reg;
        cfg_clr_next = cfg_clr_reg;
        pw_addr_next = pw_addr_reg;
        mem_wr       = '0;
        mem_rd       = '0;
        fin          = 1'b0;
        res          = '0;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = cell_addr(wr_reg, wc_reg);
                mem_wr.data = {1'b0, CH_SPACE};
                if (walk_col_end)
                begin
                    wc_next = '0;
                    wr_next = wr_reg + 6'd1;
                end
                else
                    wc_next = wc_reg + 8'd1;
            end

            ST_IDLE:
            begin
                cfg_clr_next = cfg_clr;
                if (cfg_clr)
                begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                    wr_next      = '0;
                    wc_next      = '0;
                end
            end

            ST_EXEC:
            if (slot_free)
            begin
                par_next     = 1'b0;
                wr_next      = '0;
                wc_next      = '0;
                rd_done_next = 1'b0;
                pend_next    = 1'b0;
                case (cmd_reg.action)
                    ACT_PUT:
                    begin
                        fin = 1'b1;
                        if (cur_on)
                        begin
                            mem_wr.en    = 1'b1;
                            mem_wr.addr  = cell_addr(cur_row_reg, cur_col_reg);
                            mem_wr.data  = {cmd_reg.reverse_video, cmd_reg.char_code};
                            res.accepted = 1'b1;
                        end
                    end
                    ACT_UP:
                    begin
                        fin = 1'b1;
                        if (cur_row_reg != '0)
                            cur_row_next = cur_row_reg - 6'd1;
                    end
                    ACT_DOWN:
                    begin
                        fin = 1'b1;
                        if (cmd_reg.force_req ? (cur_row_reg < ROW_LIM) : row_ok_dn)
                            cur_row_next = cur_row_reg + 6'd1;
                    end
                    ACT_LEFT:
                    begin
                        fin = 1'b1;
                        if (cur_col_reg != '0)
                            cur_col_next = cur_col_reg - 8'd1;
                        else if (cur_row_reg != '0)
                        begin
                            cur_col_next = COL_W'(cols_used - 9'd1);
                            cur_row_next = cur_row_reg - 6'd1;
                        end
                    end
                    ACT_RIGHT:
                    begin
                        fin = 1'b1;
                        if (cmd_reg.force_req)
                        begin
                            if (cur_col_reg < COL_LIM)
                                cur_col_next = cur_col_reg + 8'd1;
                        end
                        else if (col_ok_rt)
                            cur_col_next = cur_col_reg + 8'd1;
                        else if (row_ok_dn)
                        begin
                            cur_col_next = '0;
                            cur_row_next = cur_row_reg + 6'd1;
                        end
                    end
                    ACT_HOME:
                    begin
                        fin          = 1'b1;
                        cur_row_next = '0;
                        cur_col_next = '0;
                    end
                    ACT_MOVETO:
                    begin
                        fin          = 1'b1;
                        cur_row_next = {1'b0, cmd_reg.target_row};
                        cur_col_next = {1'b0, cmd_reg.target_col};
                    end
                    ACT_CLEAR:
                    begin
                        cur_row_next = '0;
                        cur_col_next = '0;
                    end
                    ACT_ENTER:
                    begin
                        cur_row_next = row_dn_f;
                        cur_col_next = '0;
                        fin          = !enter_scroll;
                    end
                    ACT_DELETE:
                    begin
                        fin = 1'b1;
                        if (cur_col_reg != '0)
                        begin
                            cur_col_next = cur_col_reg - 8'd1;
                            if (del_on)
                            begin
                                mem_wr.en   = 1'b1;
                                mem_wr.addr = cell_addr(cur_row_reg, cur_col_reg - 8'd1);
                                mem_wr.data = {1'b0, CH_SPACE};
                            end
                        end
                    end
                    ACT_READ:
                    begin
                        if (tgt_on)
                        begin
                            mem_rd.en   = 1'b1;
                            mem_rd.addr = cell_addr({1'b0, cmd_reg.target_row},
                                                    {1'b0, cmd_reg.target_col});
                        end
                        else
                        begin
                            fin           = 1'b1;
                            res.cell_char = CH_SPACE;
                        end
                    end
                    ACT_WRITE:
                    begin
                        fin = 1'b1;
                        if (tgt_on)
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = cell_addr({1'b0, cmd_reg.target_row},
                                                    {1'b0, cmd_reg.target_col});
                            mem_wr.data = {cmd_reg.reverse_video, cmd_reg.char_code};
                        end
                    end
                    ACT_QUOTES:
                        fin = !quote_go;
                    ACT_SCROLL, ACT_TAB:
                        fin = 1'b0;
                    default:
                        fin = 1'b1;
                endcase
            end

            ST_READ:
            if (slot_free)
            begin
                fin              = 1'b1;
                res.cell_char    = rdata[7:0];
                res.cell_reverse = rdata[8];
            end

            // Copy row r+1 to row r; each cell is read, then written in the cycle after its read
            ST_SCROLL:
            begin
                if (pend_reg)
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = pw_addr_reg;
                    mem_wr.data = rdata;
                end
                if (!rd_done_reg)
                begin
                    mem_rd.en    = 1'b1;
                    mem_rd.addr  = cell_addr(wr_reg + 6'd1, wc_reg);
                    pw_addr_next = cell_addr(wr_reg, wc_reg);
                    pend_next    = 1'b1;
                    if (copy_row_end && walk_col_end)
                        rd_done_next = 1'b1;
                    else if (walk_col_end)
                    begin
                        wc_next = '0;
                        wr_next = wr_reg + 6'd1;
                    end
                    else
                        wc_next = wc_reg + 8'd1;
                end
                else
                begin
                    pend_next = 1'b0;
                    wc_next   = '0;
                end
            end

            // Blank the bottom row, then step the cursor up
            ST_BLANK:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = cell_addr(ROW_W'(rows_used - 7'd1), wc_reg);
                mem_wr.data = {1'b0, CH_SPACE};
                if (walk_col_end)
                begin
                    if (cur_row_reg != '0)
                        cur_row_next = cur_row_reg - 6'd1;
                end
                else
                    wc_next = wc_reg + 8'd1;
            end

            // One tab cell per cycle
            ST_TAB:
            if (cur_on)
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = cell_addr(cur_row_reg, cur_col_reg);
                mem_wr.data = {cmd_reg.reverse_video, CH_SPACE};
                if (col_ok_rt)
                    cur_col_next = cur_col_reg + 8'd1;
                else if (row_ok_dn)
                begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + 6'd1;
                end
            end

            // Quote parity over the cells left of the cursor
            ST_QUOTE:
            begin
                if (pend_reg)
                    par_next = par_reg ^ (rdata[7:0] == CH_QUOTE);
                if (!rd_done_reg)
                begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = cell_addr(cur_row_reg, wc_reg);
                    pend_next   = 1'b1;
                    if (q_last)
                        rd_done_next = 1'b1;
                    else
                        wc_next = wc_reg + 8'd1;
                end
                else
                    pend_next = 1'b0;
            end

            ST_FIN:
            if (slot_free)
            begin
                fin            = 1'b1;
                res.quote_open = par_reg;
            end

            default:
                fin = 1'b0;
        endcase

        res.cursor_row = cur_row_next;
        res.cursor_col = cur_col_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            wr_reg      <= '0;
            wc_reg      <= '0;
            rd_done_reg <= 1'b0;
            pend_reg    <= 1'b0;
            par_reg     <= 1'b0;
            cfg_clr_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            wr_reg      <= wr_next;
            wc_reg      <= wc_next;
            rd_done_reg <= rd_done_next;
            pend_reg    <= pend_next;
            par_reg     <= par_next;
            cfg_clr_reg <= cfg_clr_next;
        end
    end

    // Command and pending write address
    always_ff @(posedge clk)
    begin
        pw_addr_reg <= pw_addr_next;
        if (start && idle)
            cmd_reg <= cmd;
    end

    // Checks
    a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> slot_free)
        else $error("result issued while output register is occupied");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!mem_wr.en && !mem_rd.en && !fin))
        else $error("memory or result activity while idle");

    a_pend_read: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCROLL || state_reg == ST_QUOTE) && pend_reg)
        |-> $past(mem_rd.en))
        else $error("pending data without a read in the previous cycle");

    a_done_pend: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCROLL || state_reg == ST_QUOTE) && rd_done_reg) |-> pend_reg)
        else $error("walk finished with no data in flight");

    a_init_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> (!fin && !idle))
        else $error("activity during reset clearing pass");

endmodule

FILE: hw/rtl/text_screen_cursor_engine.sv
// Channel   Signals                                          Handshake
// -------   ----------------------------------------------   ----------------------
// in        action char_code reverse_video force_req          in_valid / in_ready
//           target_row target_col
// out       accepted cursor_row_out cursor_col_out            out_valid / out_ready
//           cell_char cell_reverse quote_open
// cfg       cfg_index cfg_data                                cfg_valid / cfg_ready
//
// Put, write, delete, moves and home end in the execute state; read waits for registered
// memory data. Clear writes every visible cell; scroll and a scrolling enter copy rows up
// and blank the bottom row (on one row only the blank); tab writes cells up to its stop; quotes
// reads min(col, cols) cells. After reset a clearing pass writes all MAX_ROWS*MAX_COLS cells
// before in_ready and cfg_ready rise; a rows or cols config write clears the visible area.
// A stalled output holds the block in its final step; the next request is taken once loaded.
`timescale 1ns / 1ps

module text_screen_cursor_engine
    import tscr_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            action,
    input  logic [7:0]            char_code,
    input  logic                  reverse_video,
    input  logic                  force_req,
    input  logic [4:0]            target_row,
    input  logic [6:0]            target_col,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic [ROW_W-1:0]      cursor_row_out,
    output logic [COL_W-1:0]      cursor_col_out,
    output logic [7:0]            cell_char,
    output logic                  cell_reverse,
    output logic                  quote_open,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;

    logic [RU_W-1:0]   rows_used_reg, rows_used_next;
    logic [CU_W-1:0]   cols_used_reg, cols_used_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;

    logic              idle, fin, start, cfg_acc, cfg_clr, slot_free;
    cmd_t              cmd;
    res_t              res;
    mem_wr_t           mem_wr;
    mem_rd_t           mem_rd;
    logic [CELL_W-1:0] rdata;

    // Handshakes
    assign cfg_ready = idle;
    assign in_ready  = idle && !cfg_valid;
    assign start     = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_clr   = cfg_acc && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS);
    assign slot_free = !out_valid_reg || out_ready;

    assign cmd.action        = action;
    assign cmd.char_code     = char_code;
    assign cmd.reverse_video = reverse_video;
    assign cmd.force_req     = force_req;
    assign cmd.target_row    = target_row;
    assign cmd.target_col    = target_col;

    // Screen size registers, kept clamped
    always_comb
    begin
        rows_used_next = rows_used_reg;
        cols_used_next = cols_used_reg;
        if (cfg_acc && cfg_index == CFG_ROWS)
            rows_used_next = clamp_rows(cfg_data[ROW_W-1:0], MAX_ROWS);
        if (cfg_acc && cfg_index == CFG_COLS)
            cols_used_next = clamp_cols(cfg_data[COL_W-1:0], MAX_COLS);
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= clamp_rows(ROW_W'(RST_ROWS), MAX_ROWS);
            cols_used_reg <= clamp_cols(COL_W'(RST_COLS), MAX_COLS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_used_reg <= rows_used_next;
            cols_used_reg <= cols_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
            out_res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = out_res_reg.accepted;
    assign cursor_row_out = out_res_reg.cursor_row;
    assign cursor_col_out = out_res_reg.cursor_col;
    assign cell_char      = out_res_reg.cell_char;
    assign cell_reverse   = out_res_reg.cell_reverse;
    assign quote_open     = out_res_reg.quote_open;

    tscr_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_clr   (cfg_clr),
        .rows_used (rows_used_reg),
        .cols_used (cols_used_reg),
        .start     (start),
        .cmd       (cmd),
        .slot_free (slot_free),
        .idle      (idle),
        .fin       (fin),
        .res       (res),
        .mem_wr    (mem_wr),
        .mem_rd    (mem_rd),
        .rdata     (rdata)
    );

    tscr_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .rd    (mem_rd),
        .rdata (rdata)
    );

endmodule
